[sv/qde_pkg.sv]
// Shared types, constants and the quadrature transition table for the
// detent event queue. No dependencies.
package qde_pkg;

   localparam int RING_SLOTS = 16;
   localparam int SLOT_W     = $clog2(RING_SLOTS);
   localparam int FILL_W     = 4;
   localparam int CNT_W      = 5;
   localparam int SPD_W      = 4;

   localparam logic [SPD_W-1:0] SPD_RESET = 4'd4;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_POP    = 2'd1,
      FUNC_RESYNC = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      logic              event_valid;
      logic              event_dropped;
      logic [FILL_W-1:0] queued_count;
   } result_type;

   // index = old phase * 4 + new phase
   function automatic logic signed [1:0] step_of_move(input logic [3:0] idx);
      logic signed [1:0] step;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
         default:                  step = 2'sd0;
      endcase
      return step;
   endfunction

endpackage

[sv/qde_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read
// and read enable. No dependencies.
module qde_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/qde_step.sv]
// Per-item state update: phase decode, step count, ring pointers and
// ring RAM access. Depends on qde_pkg.
module qde_step (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [1:0]                 func,
   input  logic                       clk_level,
   input  logic                       dt_level,
   input  logic [qde_pkg::SPD_W-1:0]  detent_steps,
   output logic                       ram_wr_en,
   output logic [qde_pkg::SLOT_W-1:0] ram_wr_addr,
   output logic                       ram_wr_data,
   output logic                       ram_rd_en,
   output logic [qde_pkg::SLOT_W-1:0] ram_rd_addr,
   output qde_pkg::result_type        result
);

   localparam logic [qde_pkg::SLOT_W-1:0] SLOT_LAST = qde_pkg::SLOT_W'(qde_pkg::RING_SLOTS - 1);
   localparam logic [qde_pkg::SLOT_W:0]   SLOTS_EXT = (qde_pkg::SLOT_W+1)'(qde_pkg::RING_SLOTS);

   logic [1:0]                        phase_ff, phase_in;
   logic signed [qde_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [qde_pkg::SLOT_W-1:0]        wslot_ff, wslot_in;
   logic [qde_pkg::SLOT_W-1:0]        rslot_ff, rslot_in;

   logic [1:0]                        phase;
   logic signed [qde_pkg::CNT_W:0]    limit;
   logic signed [qde_pkg::CNT_W:0]    sum;
   logic [qde_pkg::SLOT_W-1:0]        wslot_next, rslot_next;
   logic [qde_pkg::SLOT_W:0]          fill;
   logic                              push_right, push_left, full;

   assign phase = {clk_level, dt_level};
   assign limit = (detent_steps == '0) ? (qde_pkg::CNT_W+1)'(1)
                : $signed({{(qde_pkg::CNT_W+1-qde_pkg::SPD_W){1'b0}}, detent_steps});
   assign sum = (qde_pkg::CNT_W+1)'(count_ff)
              + (qde_pkg::CNT_W+1)'(qde_pkg::step_of_move({phase_ff, phase}));
   assign push_right = (sum >= limit);
   assign push_left  = (sum <= -limit);

   assign wslot_next = (wslot_ff == SLOT_LAST) ? '0 : wslot_ff + 1'b1;
   assign rslot_next = (rslot_ff == SLOT_LAST) ? '0 : rslot_ff + 1'b1;
   assign full       = (wslot_next == rslot_ff);

   always_comb begin
      phase_in             = phase_ff;
      count_in             = count_ff;
      wslot_in             = wslot_ff;
      rslot_in             = rslot_ff;
      ram_wr_en            = 1'b0;
      ram_wr_data          = push_left;
      ram_rd_en            = 1'b0;
      result.event_valid   = 1'b0;
      result.event_dropped = 1'b0;
      if (accept) begin
         unique case (qde_pkg::func_type'(func))
            qde_pkg::FUNC_SAMPLE: begin
               if (phase != phase_ff) begin
                  phase_in = phase;
                  count_in = qde_pkg::CNT_W'(sum);
                  if (push_right || push_left) begin
                     count_in = '0;
                     if (full) begin
                        result.event_dropped = 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                        wslot_in  = wslot_next;
                     end
                  end
               end
            end
            qde_pkg::FUNC_POP: begin
               if (rslot_ff != wslot_ff) begin
                  result.event_valid = 1'b1;
                  ram_rd_en          = 1'b1;
                  rslot_in           = rslot_next;
               end
            end
            qde_pkg::FUNC_RESYNC: begin
               phase_in = phase;
               count_in = '0;
               wslot_in = '0;
               rslot_in = '0;
            end
            default: begin
            end
         endcase
      end
      fill = (wslot_in >= rslot_in)
           ? {1'b0, wslot_in} - {1'b0, rslot_in}
           : {1'b0, wslot_in} + SLOTS_EXT - {1'b0, rslot_in};
      result.queued_count = qde_pkg::FILL_W'(fill);
   end

   assign ram_wr_addr = wslot_ff;
   assign ram_rd_addr = rslot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         count_ff <= '0;
         wslot_ff <= '0;
         rslot_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         wslot_ff <= wslot_in;
         rslot_ff <= rslot_in;
      end
   end

endmodule

[sv/quadrature_detent_event_queue_core.sv]
// Quadrature detent event queue top: config register, state update, ring RAM
// and two-entry result pipeline. Depends on qde_pkg, qde_step and qde_ram.
// Result path: the ring RAM read and the s1 register, then the output register that drives rsp_valid.
// Throughput: 1 item per cycle while rsp_stall is low; the result pipeline holds two items under rsp_stall.
// Reset: synchronous; clears phase, step count, ring pointers and pipeline valids
// and loads the detent threshold with 4. Ring RAM contents are not cleared.
module quadrature_detent_event_queue_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic                              req_clk_level,
   input  logic                              req_dt_level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_event_valid,
   output logic                              rsp_event_left,
   output logic                              rsp_event_dropped,
   output logic [qde_pkg::FILL_W-1:0]        rsp_queued_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qde_pkg::SPD_W-1:0]         csr_data
);

   logic [qde_pkg::SPD_W-1:0]  spd_ff, spd_in;
   logic                       s1_valid_ff, s1_valid_in;
   qde_pkg::result_type        s1_res_ff;
   logic                       out_valid_ff, out_valid_in;
   qde_pkg::result_type        out_res_ff;
   logic                       out_left_ff;

   logic                       accept, s1_move;
   qde_pkg::result_type        step_res;
   logic                       ram_wr_en, ram_wr_data, ram_rd_en, ram_rd_data;
   logic [qde_pkg::SLOT_W-1:0] ram_wr_addr, ram_rd_addr;

   assign csr_ready = 1'b1;
   assign spd_in    = (csr_valid && csr_ready) ? csr_data : spd_ff;

   assign s1_move   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   qde_step u_step (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (req_func),
      .clk_level    (req_clk_level),
      .dt_level     (req_dt_level),
      .detent_steps (spd_ff),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .result       (step_res)
   );

   qde_ram #(
      .WIDTH (1),
      .DEPTH (qde_pkg::RING_SLOTS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_ff       <= qde_pkg::SPD_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         spd_ff       <= spd_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // RAM read data is held by its read enable until s1 moves on
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= step_res;
      end
      if (s1_move && s1_valid_ff) begin
         out_res_ff  <= s1_res_ff;
         out_left_ff <= s1_res_ff.event_valid & ram_rd_data;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_valid   = out_res_ff.event_valid;
   assign rsp_event_left    = out_left_ff;
   assign rsp_event_dropped = out_res_ff.event_dropped;
   assign rsp_queued_count  = out_res_ff.queued_count;

endmodule

[dv/testbench.sv]
// Testbench for quadrature_detent_event_queue_core: runs directed and random encoder
// traffic and predicts every result with a scoreboard class.
// Depends on qde_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_func = qde_pkg::FUNC_SAMPLE;
   logic                         req_clk_level = 1'b0;
   logic                         req_dt_level = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_event_valid;
   logic                         rsp_event_left;
   logic                         rsp_event_dropped;
   logic [qde_pkg::FILL_W-1:0]   rsp_queued_count;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [qde_pkg::SPD_W-1:0]    csr_data = '0;

   bit                           steady = 1'b0;
   logic [1:0]                   pin_phase = 2'd0;

   typedef struct {
      bit                         event_valid;
      bit                         event_left;
      bit                         event_dropped;
      logic [qde_pkg::FILL_W-1:0] queued_count;
   } detent_report_type;

   class detent_scoreboard;
      logic [qde_pkg::SPD_W-1:0] threshold;
      logic [1:0]                phase;
      int                        step_total;
      bit                        ring [qde_pkg::RING_SLOTS];
      int                        wr_slot;
      int                        rd_slot;
      detent_report_type         expected_reports [$];
      int                        errors;

      function new();
         threshold = qde_pkg::SPD_RESET;
         phase = 2'd0;
         step_total = 0;
         wr_slot = 0;
         rd_slot = 0;
         errors = 0;
      endfunction

      function void set_threshold(logic [qde_pkg::SPD_W-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      // position along the rotation 0 -> 2 -> 3 -> 1
      function int rotation_pos(logic [1:0] p);
         return int'({p[0], p[1] ^ p[0]});
      endfunction

      // returns 1 when the ring was full
      function bit queue_event(bit left);
         int next;
         next = (wr_slot + 1) % qde_pkg::RING_SLOTS;
         if (next == rd_slot) return 1'b1;
         ring[wr_slot] = left;
         wr_slot = next;
         return 1'b0;
      endfunction

      function void advance_encoder(qde_pkg::func_type f, bit a_level, bit b_level);
         detent_report_type rep;
         logic [1:0]        pins;
         int                limit;
         int                move_dist;
         pins = {a_level, b_level};
         rep.event_valid = 1'b0;
         rep.event_left = 1'b0;
         rep.event_dropped = 1'b0;
         case (f)
            qde_pkg::FUNC_SAMPLE: begin
               if (pins != phase) begin
                  limit = (threshold == 0) ? 1 : int'(threshold);
                  move_dist = (rotation_pos(pins) - rotation_pos(phase) + 4) % 4;
                  if (move_dist == 1) step_total++;
                  else if (move_dist == 3) step_total--;
                  phase = pins;
                  if (step_total >= limit) begin
                     rep.event_dropped = queue_event(1'b0);
                     step_total = 0;
                  end else if (step_total <= -limit) begin
                     rep.event_dropped = queue_event(1'b1);
                     step_total = 0;
                  end
               end
            end
            qde_pkg::FUNC_POP: begin
               if (rd_slot != wr_slot) begin
                  rep.event_valid = 1'b1;
                  rep.event_left = ring[rd_slot];
                  rd_slot = (rd_slot + 1) % qde_pkg::RING_SLOTS;
               end
            end
            qde_pkg::FUNC_RESYNC: begin
               phase = pins;
               step_total = 0;
               wr_slot = 0;
               rd_slot = 0;
            end
            default: ;
         endcase
         rep.queued_count = qde_pkg::FILL_W'((wr_slot + qde_pkg::RING_SLOTS - rd_slot)
                                             % qde_pkg::RING_SLOTS);
         expected_reports.push_back(rep);
      endfunction

      task report(string msg);
         $display("MISMATCH %s", msg);
         errors++;
      endtask

      task check_event_report(bit ev_valid, bit ev_left, bit ev_dropped,
                              logic [qde_pkg::FILL_W-1:0] fill);
         detent_report_type exp;
         if (expected_reports.size() == 0) begin
            report("result with no item outstanding");
            return;
         end
         exp = expected_reports.pop_front();
         if (ev_valid !== exp.event_valid)
            report($sformatf("event_valid got %0d want %0d", ev_valid, exp.event_valid));
         if (ev_left !== exp.event_left)
            report($sformatf("event_left got %0d want %0d", ev_left, exp.event_left));
         if (ev_dropped !== exp.event_dropped)
            report($sformatf("event_dropped got %0d want %0d", ev_dropped,
                             exp.event_dropped));
         if (fill !== exp.queued_count)
            report($sformatf("queued_count got %0d want %0d", fill, exp.queued_count));
      endtask
   endclass

   detent_scoreboard sb;

   quadrature_detent_event_queue_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_clk_level     (req_clk_level),
      .req_dt_level      (req_dt_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_valid   (rsp_event_valid),
      .rsp_event_left    (rsp_event_left),
      .rsp_event_dropped (rsp_event_dropped),
      .rsp_queued_count  (rsp_queued_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_event_report(rsp_event_valid, rsp_event_left, rsp_event_dropped,
                                  rsp_queued_count);
         rsp_stall <= !steady && ($urandom_range(0, 99) < 9);
      end
   end

   task automatic hold_off();
      while (!steady && $urandom_range(0, 99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_item(qde_pkg::func_type f, bit a_level, bit b_level);
      hold_off();
      req_func <= f;
      req_clk_level <= a_level;
      req_dt_level <= b_level;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.advance_encoder(f, a_level, b_level);
      if (f == qde_pkg::FUNC_SAMPLE || f == qde_pkg::FUNC_RESYNC)
         pin_phase = {a_level, b_level};
   endtask

   function automatic logic [1:0] next_phase(logic [1:0] p, bit left);
      logic [1:0] n;
      case (p)
         2'd0: n = left ? 2'd1 : 2'd2;
         2'd1: n = left ? 2'd3 : 2'd0;
         2'd2: n = left ? 2'd0 : 2'd3;
         default: n = left ? 2'd2 : 2'd1;
      endcase
      return n;
   endfunction

   task automatic turn(bit left, int n);
      logic [1:0] p;
      repeat (n) begin
         p = next_phase(pin_phase, left);
         send_item(qde_pkg::FUNC_SAMPLE, p[1], p[0]);
      end
   endtask

   task automatic pop_events(int n);
      repeat (n)
         send_item(qde_pkg::FUNC_POP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_threshold(logic [qde_pkg::SPD_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_threshold(value);
   endtask

   task automatic random_items(int n);
      bit         spin_left;
      int         r;
      logic [1:0] p;
      spin_left = 1'($urandom_range(0, 1));
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 58) begin
            if ($urandom_range(0, 99) < 12) spin_left = !spin_left;
            turn(spin_left, 1);
         end else if (r < 64) begin
            send_item(qde_pkg::FUNC_SAMPLE, pin_phase[1], pin_phase[0]);
         end else if (r < 69) begin
            p = pin_phase ^ 2'd3;
            send_item(qde_pkg::FUNC_SAMPLE, p[1], p[0]);
         end else if (r < 91) begin
            pop_events(1);
         end else if (r < 95) begin
            send_item(qde_pkg::FUNC_RESYNC, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            send_item(qde_pkg::FUNC_NONE, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, ignored code, unchanged phase, both directions,
      // invalid jump, pops down to empty, resync clearing a partial count
      pop_events(1);
      send_item(qde_pkg::FUNC_NONE, 1'b1, 1'b1);
      send_item(qde_pkg::FUNC_SAMPLE, 1'b0, 1'b0);
      turn(1'b0, 4);
      turn(1'b1, 4);
      send_item(qde_pkg::FUNC_SAMPLE, ~pin_phase[1], ~pin_phase[0]);
      pop_events(3);
      send_item(qde_pkg::FUNC_RESYNC, 1'b1, 1'b1);
      turn(1'b0, 2);
      send_item(qde_pkg::FUNC_RESYNC, 1'b0, 1'b1);

      // threshold 1: overflow the ring, then empty it
      write_threshold(4'd1);
      turn(1'b0, 18);
      pop_events(16);

      // threshold lowered under a large count
      write_threshold(4'd15);
      turn(1'b1, 10);
      write_threshold(4'd3);
      turn(1'b1, 1);
      pop_events(2);

      // zero threshold
      write_threshold(4'd0);
      turn(1'b0, 3);
      pop_events(4);

      write_threshold(4'd15);
      random_items(55);
      write_threshold(4'd1);
      steady = 1'b1;
      random_items(55);
      steady = 1'b0;
      write_threshold(4'd0);
      random_items(55);
      write_threshold(4'd7);
      random_items(55);
      write_threshold(4'($urandom_range(1, 14)));
      random_items(55);
      write_threshold(4'd2);
      random_items(55);

      drain();
      repeat (4) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
